// ===== hdl/survey_centerline_length_depth_macros.svh =====
// Assertion helpers used by the survey statistics back end.
`ifndef SURVEY_CENTERLINE_LENGTH_DEPTH_MACROS_SVH
`define SURVEY_CENTERLINE_LENGTH_DEPTH_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCL_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SCL_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== hdl/scl_pkg.sv =====
package scl_pkg;

  localparam int SCL_MAX_STATIONS = 256;
  localparam int ID_W  = 32;
  localparam int POS_W = 31;
  localparam int LEN_W = 32;
  localparam int SUM_W = 48;
  localparam int SQ_W  = 2 * (POS_W - 0) ;
  localparam int ACC_W = 64;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_REPLACED = 3'd1,
    ST_FULL     = 3'd2,
    ST_COUNTED  = 3'd3,
    ST_EXCLUDED = 3'd4,
    ST_MISSING  = 3'd5
  } status_e;

  // Work classes decided by the front end.
  typedef enum logic [1:0] {
    OP_STORE,
    OP_SHOT,
    OP_SKIP
  } op_e;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RDF,
    S_RDT,
    S_DIFF,
    S_SQ,
    S_ROOT,
    S_UPD,
    S_OUT
  } back_state_e;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_e                     op;
    logic [ID_W-1:0]         id_a;
    logic [ID_W-1:0]         id_b;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } job_t;

  // Magnitude of the difference of two positions; it always fits in 31 bits.
  function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic signed [POS_W:0] nd;
    d  = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    nd = -d;
    return d[POS_W] ? nd[POS_W-1:0] : d[POS_W-1:0];
  endfunction

endpackage

// ===== hdl/scl_ram.sv =====
module scl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/scl_front.sv =====
module scl_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [scl_pkg::ID_W-1:0]        station_id_i,
  input  logic signed [scl_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [scl_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [scl_pkg::POS_W-1:0] pos_z_i,
  input  logic [scl_pkg::ID_W-1:0]        from_station_i,
  input  logic [scl_pkg::ID_W-1:0]        to_station_i,
  input  logic                            is_surface_i,
  input  logic                            is_duplicate_i,
  input  logic                            is_splay_i,
  output logic                            job_valid_o,
  output scl_pkg::job_t                   job_o,
  input  logic                            job_pop_i
);
  import scl_pkg::*;

  job_t       q_q [2];
  job_t       job_in;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  // Classify the incoming item.
  always_comb begin
    job_in.op   = kind_i ? ((is_surface_i || is_duplicate_i || is_splay_i) ? OP_SKIP : OP_SHOT)
                         : OP_STORE;
    job_in.id_a = kind_i ? from_station_i : station_id_i;
    job_in.id_b = to_station_i;
    job_in.x    = pos_x_i;
    job_in.y    = pos_y_i;
    job_in.z    = pos_z_i;
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_pop_i && (count_q != 2'd0);
  assign job_valid_o = (count_q != 2'd0);
  assign job_o       = q_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue entries.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

// ===== hdl/scl_back.sv =====
`include "survey_centerline_length_depth_macros.svh"

module scl_back #(
  parameter int MAX_STATIONS = scl_pkg::SCL_MAX_STATIONS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  scl_pkg::job_t                    job_i,
  output logic                             job_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       status_o,
  output logic [scl_pkg::LEN_W-1:0]        shot_length_o,
  output logic [scl_pkg::SUM_W-1:0]        total_length_o,
  output logic [scl_pkg::POS_W-1:0]        depth_o,
  output logic                             depth_valid_o
);
  import scl_pkg::*;

  localparam int AddrW = $clog2(MAX_STATIONS);
  localparam logic [AddrW:0] MaxFill = (AddrW + 1)'(MAX_STATIONS);
  localparam int PosRamW = 3 * POS_W;
  localparam logic [ACC_W-1:0] RootBit0 = ACC_W'(1) << (ACC_W - 2);

  back_state_e st_q, st_d;
  job_t        job_q;
  logic        phase_q;
  logic [AddrW:0]   idx_q, fill_q;
  logic             cmp_v_q;
  logic [AddrW-1:0] cmp_idx_q, slot_f_q, slot_t_q;
  status_e          status_q;
  logic signed [POS_W-1:0] fx_q, fy_q, fz_q, tz_q;
  logic [POS_W-1:0] mag_q [3];
  logic [POS_W-1:0] mag_sel;
  logic [SQ_W-1:0]  sq_q;
  logic [ACC_W-1:0] acc_q, n_q, res_q, bit_q, trial;
  logic [1:0]       cnt_q;
  logic [LEN_W-1:0] len_q;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W:0]   sum_wide;
  logic signed [POS_W-1:0] low_q, high_q, z_min, z_max;
  logic             seen_q;
  logic             out_valid_q, out_free;
  status_e          out_status_q;
  logic [LEN_W-1:0] out_len_q;
  logic [SUM_W-1:0] out_sum_q;
  logic [POS_W-1:0] out_depth_q;
  logic             out_dv_q;

  logic [ID_W-1:0]    key, id_rdata;
  logic               hit, miss;
  logic               we;
  logic [AddrW-1:0]   waddr, id_raddr, pos_raddr;
  logic [PosRamW-1:0] pos_rdata;
  logic signed [POS_W-1:0] rx, ry, rz;

  // Station tables: ids and positions.
  scl_ram #(.WIDTH(ID_W), .DEPTH(MAX_STATIONS)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (job_q.id_a),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  scl_ram #(.WIDTH(PosRamW), .DEPTH(MAX_STATIONS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({job_q.x, job_q.y, job_q.z}),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  assign rx = pos_rdata[3*POS_W-1:2*POS_W];
  assign ry = pos_rdata[2*POS_W-1:POS_W];
  assign rz = pos_rdata[POS_W-1:0];

  // Lookup compare: a read issued last cycle is checked against the key.
  assign key  = phase_q ? job_q.id_b : job_q.id_a;
  assign hit  = cmp_v_q && (id_rdata == key);
  assign miss = !hit && (idx_q == fill_q);

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (job_valid_i) st_d = (job_i.op == OP_SKIP) ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          if (job_q.op == OP_STORE) st_d = S_OUT;
          else if (phase_q)         st_d = S_RDF;
        end else if (miss) begin
          st_d = S_OUT;
        end
      end
      S_RDF:  st_d = S_RDT;
      S_RDT:  st_d = S_DIFF;
      S_DIFF: st_d = S_SQ;
      S_SQ: begin
        if (cnt_q == 2'd3) st_d = S_ROOT;
      end
      S_ROOT: begin
        if (bit_q == ACC_W'(1)) st_d = S_UPD;
      end
      S_UPD:  st_d = S_OUT;
      S_OUT: begin
        if (out_free) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Control outputs: queue pop and table ports.
  always_comb begin
    job_pop_o = (st_q == S_IDLE) && job_valid_i;
    id_raddr  = idx_q[AddrW-1:0];
    pos_raddr = (st_q == S_RDF) ? slot_f_q : slot_t_q;
    we        = (st_q == S_SCAN) && (job_q.op == OP_STORE) &&
                (hit || (miss && (fill_q < MaxFill)));
    waddr     = hit ? cmp_idx_q : fill_q[AddrW-1:0];
  end

  // Arithmetic helpers; the new root is added to the total in the update cycle.
  always_comb begin
    case (cnt_q)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      default: mag_sel = mag_q[2];
    endcase
    trial    = res_q + bit_q;
    sum_wide = {1'b0, sum_q} + {{(SUM_W - LEN_W + 1){1'b0}}, res_q[LEN_W-1:0]};
    z_min    = (fz_q < tz_q) ? fz_q : tz_q;
    z_max    = (fz_q < tz_q) ? tz_q : fz_q;
  end

  // Control and accumulated state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      phase_q     <= 1'b0;
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      fill_q      <= '0;
      cnt_q       <= 2'd0;
      sum_q       <= '0;
      low_q       <= '0;
      high_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      case (st_q)
        S_IDLE: begin
          phase_q <= 1'b0;
          idx_q   <= '0;
          cmp_v_q <= 1'b0;
        end
        S_SCAN: begin
          if (hit) begin
            if (job_q.op == OP_SHOT && !phase_q) begin
              phase_q <= 1'b1;
              idx_q   <= '0;
              cmp_v_q <= 1'b0;
            end
          end else if (miss) begin
            if (job_q.op == OP_STORE && fill_q < MaxFill) fill_q <= fill_q + 1'b1;
          end else begin
            idx_q   <= idx_q + 1'b1;
            cmp_v_q <= 1'b1;
          end
        end
        S_DIFF: cnt_q <= 2'd0;
        S_SQ:   cnt_q <= cnt_q + 2'd1;
        S_UPD: begin
          sum_q <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
          if (!seen_q) begin
            low_q  <= z_min;
            high_q <= z_max;
          end else begin
            if (z_min < low_q)  low_q  <= z_min;
            if (z_max > high_q) high_q <= z_max;
          end
          seen_q <= 1'b1;
        end
        default: ;
      endcase
      if (st_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        job_q    <= job_i;
        len_q    <= '0;
        status_q <= ST_EXCLUDED;
      end
      S_SCAN: begin
        cmp_idx_q <= idx_q[AddrW-1:0];
        if (hit) begin
          if (job_q.op == OP_STORE) status_q <= ST_REPLACED;
          else if (!phase_q)        slot_f_q <= cmp_idx_q;
          else                      slot_t_q <= cmp_idx_q;
        end else if (miss) begin
          if (job_q.op == OP_STORE) status_q <= (fill_q < MaxFill) ? ST_STORED : ST_FULL;
          else                      status_q <= ST_MISSING;
        end
      end
      S_RDT: begin
        fx_q <= rx;
        fy_q <= ry;
        fz_q <= rz;
      end
      S_DIFF: begin
        mag_q[0] <= abs_diff(rx, fx_q);
        mag_q[1] <= abs_diff(ry, fy_q);
        mag_q[2] <= abs_diff(rz, fz_q);
        tz_q     <= rz;
        acc_q    <= '0;
      end
      S_SQ: begin
        if (cnt_q != 2'd3) sq_q <= SQ_W'(mag_sel) * SQ_W'(mag_sel);
        if (cnt_q != 2'd0) acc_q <= acc_q + {{(ACC_W - SQ_W){1'b0}}, sq_q};
        if (cnt_q == 2'd3) begin
          n_q   <= acc_q + {{(ACC_W - SQ_W){1'b0}}, sq_q};
          res_q <= '0;
          bit_q <= RootBit0;
        end
      end
      S_ROOT: begin
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_UPD: begin
        len_q    <= res_q[LEN_W-1:0];
        status_q <= ST_COUNTED;
      end
      S_OUT: begin
        if (out_free) begin
          out_status_q <= status_q;
          out_len_q    <= len_q;
          out_sum_q    <= sum_q;
          out_depth_q  <= seen_q ? POS_W'(high_q - low_q) : '0;
          out_dv_q     <= seen_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign shot_length_o  = out_len_q;
  assign total_length_o = out_sum_q;
  assign depth_o        = out_depth_q;
  assign depth_valid_o  = out_dv_q;

  `SCL_CHECK(a_fill_bound, 1'b1, fill_q <= MaxFill)
  `SCL_CHECK(a_root_bit, st_q == S_ROOT, $onehot(bit_q))
  `SCL_CHECK(a_bounds_order, seen_q, low_q <= high_q)
  `SCL_CHECK_NEXT(a_sum_grows, 1'b1, sum_q >= $past(sum_q))
  `SCL_CHECK_NEXT(a_pop_leaves_idle, st_q == S_IDLE && job_valid_i, st_q != S_IDLE)

endmodule

// ===== hdl/survey_centerline_length_depth.sv =====
// Channel | handshake                 | payload
// --------+---------------------------+----------------------------------------
// in      | in_valid_i / in_stall_o   | kind, station id, position, shot ids, flags
// out     | out_valid_o / out_stall_i | status, shot length, total, depth
//
// A station item is looked up by an id scan of the station table, one entry
// per cycle over the stored stations. A counted shot takes two scans, then
// position reads, three squares on one multiplier, and 32 steps of the
// bit-serial square root. Reset needs no clearing pass: a fill count marks the
// used slots. A two-entry queue keeps accepting items while the back end works,
// until it is full, and the output register holds a result while out_stall_i
// is high.
module survey_centerline_length_depth #(
  parameter int MAX_STATIONS = scl_pkg::SCL_MAX_STATIONS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [scl_pkg::ID_W-1:0]         station_id_i,
  input  logic signed [scl_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [scl_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [scl_pkg::POS_W-1:0] pos_z_i,
  input  logic [scl_pkg::ID_W-1:0]         from_station_i,
  input  logic [scl_pkg::ID_W-1:0]         to_station_i,
  input  logic                             is_surface_i,
  input  logic                             is_duplicate_i,
  input  logic                             is_splay_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       status_o,
  output logic [scl_pkg::LEN_W-1:0]        shot_length_o,
  output logic [scl_pkg::SUM_W-1:0]        total_length_o,
  output logic [scl_pkg::POS_W-1:0]        depth_o,
  output logic                             depth_valid_o
);
  import scl_pkg::*;

  job_t job;
  logic job_valid, job_pop;

  // Front end: accept and classify items into the queue.
  scl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .station_id_i   (station_id_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .from_station_i (from_station_i),
    .to_station_i   (to_station_i),
    .is_surface_i   (is_surface_i),
    .is_duplicate_i (is_duplicate_i),
    .is_splay_i     (is_splay_i),
    .job_valid_o    (job_valid),
    .job_o          (job),
    .job_pop_i      (job_pop)
  );

  // Back end: table lookup, length and depth statistics.
  scl_back #(.MAX_STATIONS(MAX_STATIONS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_pop_o      (job_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .shot_length_o  (shot_length_o),
    .total_length_o (total_length_o),
    .depth_o        (depth_o),
    .depth_valid_o  (depth_valid_o)
  );

endmodule

// ===== tb/survey_centerline_length_depth_tb.sv =====
`timescale 1ns / 100ps

module survey_centerline_length_depth_tb;
  import scl_pkg::*;

  localparam int  NSLOT        = SCL_MAX_STATIONS;
  localparam bit  KIND_STATION = 1'b0;
  localparam bit  KIND_SHOT    = 1'b1;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  POOL_N       = 40;
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

  // One input item as offered on the input channel.
  typedef struct {
    bit                      kind;
    logic [ID_W-1:0]         sid;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [ID_W-1:0]         from_id;
    logic [ID_W-1:0]         to_id;
    bit                      surface;
    bit                      duplicate;
    bit                      splay;
  } survey_item_t;

  // One result item as it should leave the block.
  typedef struct {
    status_e            status;
    logic [LEN_W-1:0]   shot_len;
    logic [SUM_W-1:0]   total;
    logic [POS_W-1:0]   depth;
    bit                 depth_valid;
  } survey_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    kind_i = 1'b0;
  logic [ID_W-1:0]         station_id_i = '0;
  logic signed [POS_W-1:0] pos_x_i = '0;
  logic signed [POS_W-1:0] pos_y_i = '0;
  logic signed [POS_W-1:0] pos_z_i = '0;
  logic [ID_W-1:0]         from_station_i = '0;
  logic [ID_W-1:0]         to_station_i = '0;
  logic                    is_surface_i = 1'b0;
  logic                    is_duplicate_i = 1'b0;
  logic                    is_splay_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [2:0]              status_o;
  logic [LEN_W-1:0]        shot_length_o;
  logic [SUM_W-1:0]        total_length_o;
  logic [POS_W-1:0]        depth_o;
  logic                    depth_valid_o;

  survey_centerline_length_depth dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the station table and the running statistics.
  logic [ID_W-1:0]         tbl_id [NSLOT];
  bit                      tbl_used [NSLOT];
  logic signed [POS_W-1:0] tbl_x [NSLOT];
  logic signed [POS_W-1:0] tbl_y [NSLOT];
  logic signed [POS_W-1:0] tbl_z [NSLOT];
  logic [SUM_W-1:0]        run_total = '0;
  logic signed [POS_W-1:0] z_low = '0;
  logic signed [POS_W-1:0] z_high = '0;
  bit                      z_seen = 1'b0;
  int                      stations_held = 0;

  survey_result_t pending_results[$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  counted_shots = 0;
  int  full_hits = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  logic [ID_W-1:0] id_pool [POOL_N];

  function automatic int find_station(logic [ID_W-1:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_used[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned diff_sq(logic signed [POS_W-1:0] a,
                                              logic signed [POS_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(unsigned'(d)) * longint'(unsigned'(d));
  endfunction

  function automatic void widen_bounds(logic signed [POS_W-1:0] z);
    if (!z_seen) begin
      z_low  = z;
      z_high = z;
      z_seen = 1'b1;
    end else begin
      if (z < z_low) z_low = z;
      if (z > z_high) z_high = z;
    end
  endfunction

  // Updates the shadow state with one item and returns the result it causes.
  function automatic survey_result_t survey_predict(survey_item_t it);
    survey_result_t r;
    int s, f, t;
    longint unsigned q, len;
    longint sum_room;
    longint dz;
    r.shot_len = '0;
    if (it.kind == KIND_STATION) begin
      s = find_station(it.sid);
      if (s >= 0) begin
        r.status = ST_REPLACED;
      end else begin
        for (s = 0; s < NSLOT; s++)
          if (!tbl_used[s]) break;
        if (s < NSLOT) begin
          r.status = ST_STORED;
          stations_held++;
        end else begin
          r.status = ST_FULL;
          s = -1;
        end
      end
      if (s >= 0) begin
        tbl_used[s] = 1'b1;
        tbl_id[s]   = it.sid;
        tbl_x[s]    = it.x;
        tbl_y[s]    = it.y;
        tbl_z[s]    = it.z;
      end
    end else if (it.surface || it.duplicate || it.splay) begin
      r.status = ST_EXCLUDED;
    end else begin
      f = find_station(it.from_id);
      t = find_station(it.to_id);
      if (f < 0 || t < 0) begin
        r.status = ST_MISSING;
      end else begin
        q = diff_sq(tbl_x[t], tbl_x[f]) + diff_sq(tbl_y[t], tbl_y[f])
          + diff_sq(tbl_z[t], tbl_z[f]);
        len = floor_sqrt(q);
        r.shot_len = len[LEN_W-1:0];
        sum_room = ((64'd1 << SUM_W) - 1) - run_total;
        if (len > sum_room) run_total = '1;
        else run_total = run_total + len[SUM_W-1:0];
        widen_bounds(tbl_z[f]);
        widen_bounds(tbl_z[t]);
        r.status = ST_COUNTED;
      end
    end
    dz = longint'(z_high) - longint'(z_low);
    r.depth       = z_seen ? dz[POS_W-1:0] : '0;
    r.total       = run_total;
    r.depth_valid = z_seen;
    return r;
  endfunction

  // Gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item until accepted, predicts it, then idles for a random gap, which may be none.
  task automatic send_item(survey_item_t it);
    int gap;
    in_valid_i     <= 1'b1;
    kind_i         <= it.kind;
    station_id_i   <= it.sid;
    pos_x_i        <= it.x;
    pos_y_i        <= it.y;
    pos_z_i        <= it.z;
    from_station_i <= it.from_id;
    to_station_i   <= it.to_id;
    is_surface_i   <= it.surface;
    is_duplicate_i <= it.duplicate;
    is_splay_i     <= it.splay;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(survey_predict(it));
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic survey_item_t rand_item();
    survey_item_t it;
    it.kind      = 1'($urandom_range(0, 1));
    it.sid       = $urandom;
    it.x         = POS_W'($urandom);
    it.y         = POS_W'($urandom);
    it.z         = POS_W'($urandom);
    it.from_id   = $urandom;
    it.to_id     = $urandom;
    it.surface   = 1'($urandom_range(0, 1));
    it.duplicate = 1'($urandom_range(0, 1));
    it.splay     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic survey_item_t station_item(logic [ID_W-1:0] id,
      logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
      logic signed [POS_W-1:0] z);
    survey_item_t it;
    it      = rand_item();
    it.kind = KIND_STATION;
    it.sid  = id;
    it.x    = x;
    it.y    = y;
    it.z    = z;
    return it;
  endfunction

  function automatic survey_item_t shot_item(logic [ID_W-1:0] a, logic [ID_W-1:0] b,
      bit sf, bit dp, bit sp);
    survey_item_t it;
    it           = rand_item();
    it.kind      = KIND_SHOT;
    it.from_id   = a;
    it.to_id     = b;
    it.surface   = sf;
    it.duplicate = dp;
    it.splay     = sp;
    return it;
  endfunction

  // Positions: full range at times, else a small cave-sized spread.
  function automatic logic signed [POS_W-1:0] rand_pos();
    logic signed [POS_W-1:0] p;
    p = POS_W'($urandom);
    if ($urandom_range(0, 3) != 0)
      p = POS_W'($signed($urandom_range(0, 200000)) - 100000);
    return p;
  endfunction

  // Extremes of the fields, every status but ST_FULL and each special case.
  task automatic test_directed();
    send_item(shot_item(32'h0, 32'h0, 0, 0, 0));
    send_item(station_item(32'h0, POS_MIN, POS_MIN, POS_MIN));
    send_item(station_item(32'hFFFF_FFFF, POS_MAX, POS_MAX, POS_MAX));
    send_item(shot_item(32'h0, 32'hFFFF_FFFF, 0, 0, 0));
    send_item(shot_item(32'hFFFF_FFFF, 32'h0, 0, 0, 0));
    send_item(shot_item(32'h0, 32'hFFFF_FFFF, 1, 0, 0));
    send_item(shot_item(32'h0, 32'hFFFF_FFFF, 0, 1, 0));
    send_item(shot_item(32'h0, 32'hFFFF_FFFF, 0, 0, 1));
    send_item(shot_item(32'h0, 32'hFFFF_FFFF, 1, 1, 1));
    send_item(shot_item(32'h5, 32'h0, 0, 0, 0));
    send_item(shot_item(32'h0, 32'h5, 0, 0, 0));
    send_item(station_item(32'h0, 3, 4, 0));
    send_item(station_item(32'h1, 0, 0, 0));
    send_item(shot_item(32'h1, 32'h0, 0, 0, 0));
    send_item(shot_item(32'h0, 32'h0, 0, 0, 0));
    send_item(station_item(32'hFFFF_FFFF, POS_MIN, POS_MAX, -1));
    send_item(shot_item(32'h1, 32'hFFFF_FFFF, 0, 0, 0));
    send_item(station_item(32'hA5A5_5A5A, 1, -1, 12345));
    send_item(shot_item(32'hA5A5_5A5A, 32'h1, 0, 0, 0));
    wait_drained();
  endtask

  // Mostly well-formed surveys on a pool of ids, with some noise.
  task automatic test_random_survey(int n);
    survey_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        it = station_item(id_pool[$urandom_range(0, POOL_N - 1)],
                          rand_pos(), rand_pos(), rand_pos());
      else if (r < 80)
        it = shot_item(id_pool[$urandom_range(0, POOL_N - 1)],
                       id_pool[$urandom_range(0, POOL_N - 1)],
                       $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
                       $urandom_range(0, 19) == 0);
      else if (r < 92)
        it = rand_item();
      else
        it = station_item($urandom, rand_pos(), rand_pos(), rand_pos());
      send_item(it);
      if (it.kind == KIND_SHOT && pending_results[$].status == ST_COUNTED)
        counted_shots++;
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering items back to back.
  task automatic test_output_backpressure();
    no_idle  = 1'b1;
    hold_req = ~hold_req;
    for (int i = 0; i < 16; i++)
      send_item(shot_item(id_pool[$urandom_range(0, 3)], id_pool[$urandom_range(0, 3)],
                          0, 0, 0));
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Fills the table to capacity, then checks full, replace and shots on it.
  task automatic test_full_table();
    logic [ID_W-1:0] id;
    id = 32'h7000_0000;
    while (stations_held < NSLOT) begin
      while (find_station(id) >= 0) id++;
      send_item(station_item(id, rand_pos(), rand_pos(), rand_pos()));
    end
    for (int i = 0; i < 30; i++) begin
      case ($urandom_range(0, 2))
        0: begin
          send_item(station_item(id + 32'h100 + i, rand_pos(), rand_pos(), rand_pos()));
          full_hits++;
        end
        1: send_item(station_item(id_pool[$urandom_range(0, POOL_N - 1)],
                                  rand_pos(), rand_pos(), rand_pos()));
        default: send_item(shot_item(id_pool[$urandom_range(0, POOL_N - 1)],
                                     tbl_id[$urandom_range(0, NSLOT - 1)], 0, 0, 0));
      endcase
    end
    wait_drained();
  endtask

  // Random receiver stalls, plus a long counted hold-off on request.
  bit hold_ack = 1'b0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= pick_gap() > 0;
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    survey_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation pending");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          errors++;
        end
        if (shot_length_o !== e.shot_len) begin
          $error("shot_length: expected %0d, got %0d", e.shot_len, shot_length_o);
          errors++;
        end
        if (total_length_o !== e.total) begin
          $error("total_length: expected %0d, got %0d", e.total, total_length_o);
          errors++;
        end
        if (depth_o !== e.depth) begin
          $error("depth: expected %0d, got %0d", e.depth, depth_o);
          errors++;
        end
        if (depth_valid_o !== e.depth_valid) begin
          $error("depth_valid: expected %0d, got %0d", e.depth_valid, depth_valid_o);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
    for (int i = 0; i < POOL_N; i++)
      id_pool[i] = (i < POOL_N / 2) ? 32'h100 + i : $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_survey(490);
    test_output_backpressure();
    test_random_survey(490);
    test_full_table();
    repeat (200) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      errors++;
    end
    $display("Sent %0d items, checked %0d results, %0d shots counted in random phases,",
             items_sent, results_seen, counted_shots);
    $display("table filled to %0d stations with %0d overflow stores.", NSLOT, full_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/scl_pkg.sv
hdl/scl_ram.sv
hdl/scl_front.sv
hdl/scl_back.sv
hdl/survey_centerline_length_depth.sv
tb/survey_centerline_length_depth_tb.sv
